FILE: sv/t2b_pkg.sv
// Package for the text-to-bencode converter: codes, character constants, state types.
`default_nettype none
package t2b_pkg;

  localparam int MAX_STRING_DEF = 32;

  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_NINE   = 8'd57;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_RBRK   = 8'h5D;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_I      = 8'h69;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_D      = 8'h64;
  localparam logic [7:0] CH_L      = 8'h6C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_HEX   = 2'd1;
  localparam logic [1:0] ERR_UNTERM = 2'd2;
  localparam logic [1:0] ERR_LONG  = 2'd3;

  typedef enum logic [2:0] {
    MD_IDLE,
    MD_INT,
    MD_STR,
    MD_ESC,
    MD_HEX1,
    MD_HEX2,
    MD_ERR
  } mode_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_QUEUE,
    SQ_READ,
    SQ_DUMP,
    SQ_ERROR
  } seq_t;

endpackage
`default_nettype wire

FILE: sv/t2b_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module t2b_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [AW-1:0]          waddr,
  input  wire logic [WIDTH-1:0]       wdata,
  input  wire logic [AW-1:0]          raddr,
  output logic      [WIDTH-1:0]       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: sv/text_to_bencode_converter.sv
// Top level of the text-to-bencode converter: parser, output sequencer, output register.
//
// Usage: the s_ channel takes one byte of bracketed text per word (s_tdata), with
// s_tlast marking the final byte of a document. The m_ channel gives bencode bytes in
// m_tdata, with m_tuser carrying an error code (0 none, 1 bad hex digit, 2 input ended
// unterminated, 3 string too long) and m_tlast on the last word caused by an input byte.
// An input byte is parsed in its accept cycle; its results (up to three token bytes, or
// a string length and colon, then the buffered string bytes, then one error word) are
// queued and sent by a sequencer through a single output register. A byte that causes
// no word leaves s_tready high; otherwise s_tready drops until the last word is loaded into
// the output register. Each buffered string byte is read from the string buffer RAM, whose
// read is registered, before it is loaded. Results are registered in the sequencer before
// they reach the output register. A stalled m_tready holds the output register and the sequencer; the
// input stays blocked. Synchronous reset returns the parser to idle outside any token,
// clears the string count and empties the output; the buffer RAM needs no clearing.
`default_nettype none
module text_to_bencode_converter #(
  parameter int MAX_STRING = t2b_pkg::MAX_STRING_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  input  wire logic       s_tlast,   // final_byte
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic      [7:0] m_tdata,   // [7:0] out_byte
  output logic            m_tlast,   // last_of_run
  output logic      [1:0] m_tuser    // [1:0] error
);

  localparam int CNT_W = $clog2(MAX_STRING + 1);
  localparam int AW    = (MAX_STRING > 1) ? $clog2(MAX_STRING) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_STRING);

  // parser state
  t2b_pkg::mode_t   mode, mode_next;
  logic [3:0]       hex_hi, hex_hi_next;
  logic [CNT_W-1:0] count, count_next;

  // sequencer state
  t2b_pkg::seq_t    sq, sq_next;
  logic [7:0]       q [3];
  logic [1:0]       qn;
  logic [1:0]       qi;
  logic             dump;
  logic [1:0]       err;
  logic [CNT_W-1:0] idx;

  // parser outputs for the word being accepted
  logic [7:0]       pq [3];
  logic [1:0]       pqn;
  logic             pdump;
  logic [1:0]       perr;
  logic             push;
  logic [7:0]       push_data;

  logic             accept;
  logic             out_free;
  logic             load;
  logic [7:0]       ld_byte;
  logic             ld_last;
  logic [1:0]       ld_err;
  logic [7:0]       rdata;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (sq == t2b_pkg::SQ_IDLE);

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) r = {1'b1, 4'(c - 8'h30)};
    else if (c inside {[8'h41:8'h46]}) r = {1'b1, 4'(c - 8'h37)};
    else if (c inside {[8'h61:8'h66]}) r = {1'b1, 4'(c - 8'h57)};
    return r;
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h6E:   r = 8'd10;
      8'h61:   r = 8'd7;
      8'h62:   r = 8'd8;
      8'h65:   r = 8'd27;
      8'h66:   r = 8'd12;
      8'h72:   r = 8'd13;
      8'h74:   r = 8'd9;
      8'h76:   r = 8'd11;
      default: r = c;
    endcase
    return r;
  endfunction

  // tens digit of a length below 70 by comparison against multiples of ten
  function automatic logic [2:0] dec_tens(input logic [CNT_W-1:0] n);
    logic [2:0] t;
    t = 3'd0;
    for (int k = 1; k < 7; k++) begin
      if (7'(n) >= 7'(k * 10)) t = 3'(k);
    end
    return t;
  endfunction

  always_comb begin
    logic       is_dig;
    logic       tok;
    logic [4:0] hv;
    logic [2:0] tens;
    logic [6:0] ones;
    logic [1:0] n;
    is_dig = (s_tdata >= t2b_pkg::CH_ZERO) && (s_tdata <= t2b_pkg::CH_NINE);
    tok    = 1'b0;
    hv     = hex_value(s_tdata);
    tens   = dec_tens(count);
    ones   = 7'(count) - 7'(tens) * 7'd10;
    n      = 2'd0;
    pq[0]  = 8'd0;
    pq[1]  = 8'd0;
    pq[2]  = 8'd0;
    pdump  = 1'b0;
    perr   = t2b_pkg::ERR_NONE;
    push   = 1'b0;
    push_data   = s_tdata;
    mode_next   = mode;
    hex_hi_next = hex_hi;
    count_next  = count;

    case (mode)
      t2b_pkg::MD_ERR: begin
        if (s_tlast) mode_next = t2b_pkg::MD_IDLE;
      end
      t2b_pkg::MD_INT: begin
        if (is_dig) begin
          pq[0] = s_tdata;
          n = 2'd1;
        end else begin
          pq[0] = t2b_pkg::CH_E;
          n = 2'd1;
          mode_next = t2b_pkg::MD_IDLE;
          tok = 1'b1;
        end
      end
      t2b_pkg::MD_STR: begin
        if (s_tdata == t2b_pkg::CH_QUOTE) begin
          if (tens != 3'd0) begin
            pq[n] = t2b_pkg::CH_ZERO + 8'(tens);
            n = n + 2'd1;
          end
          pq[n] = t2b_pkg::CH_ZERO + 8'(ones);
          n = n + 2'd1;
          pq[n] = t2b_pkg::CH_COLON;
          n = n + 2'd1;
          pdump = (count != '0);
          mode_next = t2b_pkg::MD_IDLE;
        end else if (s_tdata == t2b_pkg::CH_BSLASH) begin
          mode_next = t2b_pkg::MD_ESC;
        end else begin
          push = 1'b1;
        end
      end
      t2b_pkg::MD_ESC: begin
        if (s_tdata == t2b_pkg::CH_X) begin
          mode_next = t2b_pkg::MD_HEX1;
        end else begin
          push = 1'b1;
          push_data = unescape(s_tdata);
          mode_next = t2b_pkg::MD_STR;
        end
      end
      t2b_pkg::MD_HEX1: begin
        if (!hv[4]) perr = t2b_pkg::ERR_HEX;
        else begin
          hex_hi_next = hv[3:0];
          mode_next = t2b_pkg::MD_HEX2;
        end
      end
      t2b_pkg::MD_HEX2: begin
        if (!hv[4]) perr = t2b_pkg::ERR_HEX;
        else begin
          push = 1'b1;
          push_data = {hex_hi, hv[3:0]};
          mode_next = t2b_pkg::MD_STR;
        end
      end
      default: begin
        mode_next = t2b_pkg::MD_IDLE;
        tok = 1'b1;
      end
    endcase

    if (tok) begin
      if (s_tdata == t2b_pkg::CH_LPAR) begin
        pq[n] = t2b_pkg::CH_D;
        n = n + 2'd1;
      end else if (s_tdata == t2b_pkg::CH_LBRK) begin
        pq[n] = t2b_pkg::CH_L;
        n = n + 2'd1;
      end else if (s_tdata == t2b_pkg::CH_RPAR || s_tdata == t2b_pkg::CH_RBRK) begin
        pq[n] = t2b_pkg::CH_E;
        n = n + 2'd1;
      end else if (is_dig || s_tdata == t2b_pkg::CH_PLUS || s_tdata == t2b_pkg::CH_MINUS) begin
        pq[n] = t2b_pkg::CH_I;
        pq[n + 2'd1] = s_tdata;
        n = n + 2'd2;
        mode_next = t2b_pkg::MD_INT;
      end else if (s_tdata == t2b_pkg::CH_QUOTE) begin
        count_next = '0;
        mode_next = t2b_pkg::MD_STR;
      end
    end

    if (push) begin
      if (count >= CNT_MAX) begin
        perr = t2b_pkg::ERR_LONG;
        push = 1'b0;
      end else begin
        count_next = count + CNT_W'(1);
      end
    end

    if (mode != t2b_pkg::MD_ERR) begin
      if (perr == t2b_pkg::ERR_NONE && s_tlast && mode_next != t2b_pkg::MD_IDLE) begin
        perr = t2b_pkg::ERR_UNTERM;
      end
      if (perr != t2b_pkg::ERR_NONE) begin
        mode_next = s_tlast ? t2b_pkg::MD_IDLE : t2b_pkg::MD_ERR;
      end else if (s_tlast) begin
        mode_next = t2b_pkg::MD_IDLE;
      end
    end
    pqn = n;
  end

  t2b_ram #(
    .WIDTH (8),
    .DEPTH (MAX_STRING)
  ) u_buf (
    .clk   (clk),
    .we    (accept && push),
    .waddr (count[AW-1:0]),
    .wdata (push_data),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  // sequencer next state
  always_comb begin
    sq_next = sq;
    case (sq)
      t2b_pkg::SQ_IDLE: begin
        if (accept) begin
          if (pqn != 2'd0) sq_next = t2b_pkg::SQ_QUEUE;
          else if (perr != t2b_pkg::ERR_NONE) sq_next = t2b_pkg::SQ_ERROR;
        end
      end
      t2b_pkg::SQ_QUEUE: begin
        if (out_free && qi == qn - 2'd1) begin
          if (dump) sq_next = t2b_pkg::SQ_READ;
          else if (err != t2b_pkg::ERR_NONE) sq_next = t2b_pkg::SQ_ERROR;
          else sq_next = t2b_pkg::SQ_IDLE;
        end
      end
      t2b_pkg::SQ_READ: sq_next = t2b_pkg::SQ_DUMP;
      t2b_pkg::SQ_DUMP: begin
        if (out_free) begin
          sq_next = (idx == count - CNT_W'(1)) ? t2b_pkg::SQ_IDLE : t2b_pkg::SQ_READ;
        end
      end
      t2b_pkg::SQ_ERROR: begin
        if (out_free) sq_next = t2b_pkg::SQ_IDLE;
      end
      default: sq_next = t2b_pkg::SQ_IDLE;
    endcase
  end

  // sequencer outputs into the output register
  always_comb begin
    load    = 1'b0;
    ld_byte = 8'd0;
    ld_last = 1'b0;
    ld_err  = t2b_pkg::ERR_NONE;
    case (sq)
      t2b_pkg::SQ_QUEUE: begin
        load    = out_free;
        ld_byte = q[qi];
        ld_last = (qi == qn - 2'd1) && !dump && (err == t2b_pkg::ERR_NONE);
      end
      t2b_pkg::SQ_DUMP: begin
        load    = out_free;
        ld_byte = rdata;
        ld_last = (idx == count - CNT_W'(1));
      end
      t2b_pkg::SQ_ERROR: begin
        load    = out_free;
        ld_last = 1'b1;
        ld_err  = err;
      end
      default: load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= t2b_pkg::MD_IDLE;
      hex_hi   <= 4'd0;
      count    <= '0;
      sq       <= t2b_pkg::SQ_IDLE;
      qn       <= 2'd0;
      qi       <= 2'd0;
      dump     <= 1'b0;
      err      <= t2b_pkg::ERR_NONE;
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      sq <= sq_next;
      if (accept) begin
        mode   <= mode_next;
        hex_hi <= hex_hi_next;
        count  <= count_next;
        qn     <= pqn;
        qi     <= 2'd0;
        dump   <= pdump;
        err    <= perr;
        idx    <= '0;
      end
      if (load && sq == t2b_pkg::SQ_QUEUE) qi <= qi + 2'd1;
      if (load && sq == t2b_pkg::SQ_DUMP) idx <= idx + CNT_W'(1);
      if (load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // payload: queued bytes and output word
  always_ff @(posedge clk) begin
    if (accept) begin
      q[0] <= pq[0];
      q[1] <= pq[1];
      q[2] <= pq[2];
    end
    if (load) begin
      m_tdata <= ld_byte;
      m_tlast <= ld_last;
      m_tuser <= ld_err;
    end
  end

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// Testbench for text_to_bencode_converter: directed and random documents checked word by word.
`default_nettype none
module tb;

  localparam int MAX_STRING  = t2b_pkg::MAX_STRING_DEF;
  localparam int SAW         = (MAX_STRING > 1) ? $clog2(MAX_STRING) : 1;
  localparam int LIMIT       = 500000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN       = 40;
  localparam int ITEMS       = 320;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] err;
  } bencode_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] data_byte
  logic       s_tlast = 1'b0;    // final_byte
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [7:0] out_byte
  logic       m_tlast;           // last_of_run
  logic [1:0] m_tuser;           // [1:0] error

  text_to_bencode_converter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #10 clk = ~clk;

  // predictor state
  t2b_pkg::mode_t pmode = t2b_pkg::MD_IDLE;
  logic [3:0]    hex_hi = 4'h0;
  logic [7:0]    str_buf [0:MAX_STRING-1];
  logic [5:0]    str_cnt = 6'd0;
  bencode_word_t step_words[$];
  bencode_word_t expected_bencode[$];

  bit   quiet = 1'b0;
  logic hold_on = 1'b0;
  event hold_go;
  int   mismatches = 0;
  int   words_seen = 0;
  int   bytes_sent = 0;
  int   live_items = 0;
  int   documents = 0;

  function automatic void add_word(input logic [7:0] b, input logic [1:0] err);
    bencode_word_t w;
    w.data = b;
    w.last = 1'b0;
    w.err  = err;
    step_words.push_back(w);
  endfunction

  function automatic int hex_value(input logic [7:0] c);
    if (c >= t2b_pkg::CH_ZERO && c <= t2b_pkg::CH_NINE) return int'(c - t2b_pkg::CH_ZERO);
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return -1;
  endfunction

  function automatic logic [1:0] push_byte(input logic [7:0] b);
    if (str_cnt >= MAX_STRING) return t2b_pkg::ERR_LONG;
    str_buf[str_cnt[SAW-1:0]] = b;
    str_cnt++;
    return t2b_pkg::ERR_NONE;
  endfunction

  function automatic void outside_token(input logic [7:0] c);
    if (c == t2b_pkg::CH_LPAR) add_word(t2b_pkg::CH_D, t2b_pkg::ERR_NONE);
    else if (c == t2b_pkg::CH_LBRK) add_word(t2b_pkg::CH_L, t2b_pkg::ERR_NONE);
    else if (c == t2b_pkg::CH_RPAR || c == t2b_pkg::CH_RBRK)
      add_word(t2b_pkg::CH_E, t2b_pkg::ERR_NONE);
    else if ((c >= t2b_pkg::CH_ZERO && c <= t2b_pkg::CH_NINE) || c == t2b_pkg::CH_PLUS ||
             c == t2b_pkg::CH_MINUS) begin
      add_word(t2b_pkg::CH_I, t2b_pkg::ERR_NONE);
      add_word(c, t2b_pkg::ERR_NONE);
      pmode = t2b_pkg::MD_INT;
    end else if (c == t2b_pkg::CH_QUOTE) begin
      str_cnt = 6'd0;
      pmode = t2b_pkg::MD_STR;
    end
  endfunction

  // Work out the bencode words caused by one accepted input byte.
  function automatic void encode_byte(input logic [7:0] c, input logic fin);
    logic [1:0] err;
    logic [7:0] lit;
    int         hv;
    err = t2b_pkg::ERR_NONE;
    step_words.delete();
    if (pmode == t2b_pkg::MD_ERR) begin
      if (fin) pmode = t2b_pkg::MD_IDLE;
      return;
    end
    case (pmode)
      t2b_pkg::MD_INT: begin
        if (c >= t2b_pkg::CH_ZERO && c <= t2b_pkg::CH_NINE) add_word(c, t2b_pkg::ERR_NONE);
        else begin
          add_word(t2b_pkg::CH_E, t2b_pkg::ERR_NONE);
          pmode = t2b_pkg::MD_IDLE;
          outside_token(c);
        end
      end
      t2b_pkg::MD_STR: begin
        if (c == t2b_pkg::CH_QUOTE) begin
          if (str_cnt >= 10)
            add_word(t2b_pkg::CH_ZERO + 8'(str_cnt / 10), t2b_pkg::ERR_NONE);
          add_word(t2b_pkg::CH_ZERO + 8'(str_cnt % 10), t2b_pkg::ERR_NONE);
          add_word(t2b_pkg::CH_COLON, t2b_pkg::ERR_NONE);
          for (int i = 0; i < int'(str_cnt); i++)
            add_word(str_buf[SAW'(i)], t2b_pkg::ERR_NONE);
          pmode = t2b_pkg::MD_IDLE;
        end else if (c == t2b_pkg::CH_BSLASH) begin
          pmode = t2b_pkg::MD_ESC;
        end else begin
          err = push_byte(c);
        end
      end
      t2b_pkg::MD_ESC: begin
        if (c == t2b_pkg::CH_X) begin
          pmode = t2b_pkg::MD_HEX1;
        end else begin
          case (c)
            "n":     lit = 8'd10;
            "a":     lit = 8'd7;
            "b":     lit = 8'd8;
            "e":     lit = 8'd27;
            "f":     lit = 8'd12;
            "r":     lit = 8'd13;
            "t":     lit = 8'd9;
            "v":     lit = 8'd11;
            default: lit = c;
          endcase
          err = push_byte(lit);
          pmode = t2b_pkg::MD_STR;
        end
      end
      t2b_pkg::MD_HEX1: begin
        hv = hex_value(c);
        if (hv < 0) err = t2b_pkg::ERR_HEX;
        else begin
          hex_hi = 4'(hv);
          pmode = t2b_pkg::MD_HEX2;
        end
      end
      t2b_pkg::MD_HEX2: begin
        hv = hex_value(c);
        if (hv < 0) err = t2b_pkg::ERR_HEX;
        else begin
          err = push_byte({hex_hi, 4'(hv)});
          pmode = t2b_pkg::MD_STR;
        end
      end
      default: begin
        pmode = t2b_pkg::MD_IDLE;
        outside_token(c);
      end
    endcase

    // an error from the byte itself wins over the unterminated code
    if (err == t2b_pkg::ERR_NONE && fin && pmode != t2b_pkg::MD_IDLE) err = t2b_pkg::ERR_UNTERM;
    if (err != t2b_pkg::ERR_NONE) begin
      add_word(8'h00, err);
      pmode = fin ? t2b_pkg::MD_IDLE : t2b_pkg::MD_ERR;
    end else if (fin) begin
      pmode = t2b_pkg::MD_IDLE;
    end
    if (step_words.size() > 0) step_words[$].last = 1'b1;
    foreach (step_words[i]) expected_bencode.push_back(step_words[i]);
  endfunction

  // Offer one byte; return at the edge where it is accepted. Valid stays high.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while (!quiet && $urandom_range(99) < 9) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    if (pmode != t2b_pkg::MD_ERR) live_items++;
    if (fin) documents++;
    encode_byte(b, fin);
  endtask

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (hold_on) m_tready <= 1'b0;
    else m_tready <= quiet || ($urandom_range(99) >= 9);
  end

  // long receiver hold-off, counted here
  always begin
    @(hold_go);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin : check_output
    bencode_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      words_seen++;
      if (expected_bencode.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: data=%h last=%b err=%0d", m_tdata, m_tlast, m_tuser);
      end else begin
        want = expected_bencode.pop_front();
        if (m_tdata !== want.data || m_tlast !== want.last || m_tuser !== want.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d: expected data=%h last=%b err=%0d, got data=%h last=%b err=%0d",
                     words_seen, want.data, want.last, want.err, m_tdata, m_tlast, m_tuser);
        end
      end
    end
  end

  task automatic test_containers();
    send_byte(t2b_pkg::CH_LPAR, 1'b0);
    send_byte(t2b_pkg::CH_LBRK, 1'b0);
    send_byte("q", 1'b0);       // dropped outside a token
    send_byte(t2b_pkg::CH_RBRK, 1'b0);
    send_byte(t2b_pkg::CH_RPAR, 1'b1);
  endtask

  task automatic test_integers();
    send_byte(t2b_pkg::CH_MINUS, 1'b0);
    send_byte("7", 1'b0);
    send_byte(",", 1'b0);
    send_byte("5", 1'b0);
    send_byte(t2b_pkg::CH_RBRK, 1'b0);   // closes the integer, then the list
    send_byte(t2b_pkg::CH_PLUS, 1'b1);   // sign as final byte: unterminated
    send_byte(t2b_pkg::CH_NINE, 1'b1);   // digit as final byte
  endtask

  task automatic test_strings();
    send_byte(t2b_pkg::CH_QUOTE, 1'b0);
    send_byte(t2b_pkg::CH_QUOTE, 1'b0);  // empty string
    send_byte(t2b_pkg::CH_QUOTE, 1'b0);
    send_byte("a", 1'b0);
    send_byte(t2b_pkg::CH_BSLASH, 1'b0);
    send_byte("n", 1'b0);
    send_byte(t2b_pkg::CH_BSLASH, 1'b0);
    send_byte(t2b_pkg::CH_QUOTE, 1'b0);  // escaped quote stands for itself
    send_byte(t2b_pkg::CH_BSLASH, 1'b0);
    send_byte(t2b_pkg::CH_X, 1'b0);
    send_byte("F", 1'b0);
    send_byte("f", 1'b0);
    send_byte(t2b_pkg::CH_QUOTE, 1'b0);
    send_byte(t2b_pkg::CH_RPAR, 1'b1);
  endtask

  task automatic test_errors();
    // bad first hex digit, then bytes swallowed up to the final byte
    send_byte(t2b_pkg::CH_QUOTE, 1'b0);
    send_byte(t2b_pkg::CH_BSLASH, 1'b0);
    send_byte(t2b_pkg::CH_X, 1'b0);
    send_byte("g", 1'b0);
    send_byte(t2b_pkg::CH_LPAR, 1'b0);
    send_byte(t2b_pkg::CH_LPAR, 1'b1);
    // bad second hex digit on the final byte
    send_byte(t2b_pkg::CH_QUOTE, 1'b0);
    send_byte(t2b_pkg::CH_BSLASH, 1'b0);
    send_byte(t2b_pkg::CH_X, 1'b0);
    send_byte("4", 1'b0);
    send_byte("q", 1'b1);
    // string left open
    send_byte(t2b_pkg::CH_QUOTE, 1'b0);
    send_byte("a", 1'b1);
  endtask

  task automatic test_overflow();
    send_byte(t2b_pkg::CH_QUOTE, 1'b0);
    for (int i = 0; i <= MAX_STRING; i++) send_byte(8'("a" + i % 26), 1'b0);
    send_byte(t2b_pkg::CH_QUOTE, 1'b0);
    send_byte(t2b_pkg::CH_RBRK, 1'b1);
  endtask

  // Hold the receiver off while a full-length string is offered behind a list opener.
  task automatic test_backpressure();
    -> hold_go;
    send_byte(t2b_pkg::CH_LBRK, 1'b0);
    send_byte(t2b_pkg::CH_QUOTE, 1'b0);
    for (int i = 0; i < MAX_STRING; i++) begin
      if (i % 8 == 3) begin
        send_byte(t2b_pkg::CH_BSLASH, 1'b0);
        send_byte("t", 1'b0);
      end else begin
        send_byte(8'(8'h30 + i), 1'b0);
      end
    end
    send_byte(t2b_pkg::CH_QUOTE, 1'b0);
    send_byte(t2b_pkg::CH_RBRK, 1'b1);
  endtask

  task automatic send_document(input int tokens);
    string      hexch;
    string      escch;
    int         pick;
    int         len;
    logic [7:0] c;
    hexch = "0123456789abcdefABCDEF";
    escch = "nabefrtv";
    for (int t = 0; t < tokens; t++) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        send_byte($urandom_range(1) ? t2b_pkg::CH_LPAR : t2b_pkg::CH_LBRK, 1'b0);
      end else if (pick < 30) begin
        send_byte($urandom_range(1) ? t2b_pkg::CH_RPAR : t2b_pkg::CH_RBRK, 1'b0);
      end else if (pick < 50) begin
        if ($urandom_range(99) < 30)
          send_byte($urandom_range(1) ? t2b_pkg::CH_PLUS : t2b_pkg::CH_MINUS, 1'b0);
        len = $urandom_range(1, 5);
        for (int k = 0; k < len; k++)
          send_byte(8'(t2b_pkg::CH_ZERO + $urandom_range(9)), 1'b0);
      end else if (pick < 85) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(28, 34) : $urandom_range(0, 10);
        send_byte(t2b_pkg::CH_QUOTE, 1'b0);
        for (int k = 0; k < len; k++) begin
          pick = $urandom_range(99);
          if (pick < 70) begin
            do c = 8'($urandom_range(255));
            while (c == t2b_pkg::CH_QUOTE || c == t2b_pkg::CH_BSLASH);
            send_byte(c, 1'b0);
          end else if (pick < 85) begin
            send_byte(t2b_pkg::CH_BSLASH, 1'b0);
            if ($urandom_range(1)) send_byte(escch[$urandom_range(7)], 1'b0);
            else send_byte(8'($urandom_range(255)), 1'b0);
          end else begin
            send_byte(t2b_pkg::CH_BSLASH, 1'b0);
            send_byte(t2b_pkg::CH_X, 1'b0);
            repeat (2) begin
              if ($urandom_range(99) < 3) send_byte(8'($urandom_range(255)), 1'b0);
              else send_byte(hexch[$urandom_range(21)], 1'b0);
            end
          end
        end
        if ($urandom_range(19) != 0) send_byte(t2b_pkg::CH_QUOTE, 1'b0);
      end else begin
        send_byte(8'($urandom_range(255)), 1'b0);
      end
    end
    pick = $urandom_range(99);
    if (pick < 40) send_byte($urandom_range(1) ? t2b_pkg::CH_RPAR : t2b_pkg::CH_RBRK, 1'b1);
    else if (pick < 70) send_byte(8'($urandom_range(255)), 1'b1);
    else send_byte(8'(t2b_pkg::CH_ZERO + $urandom_range(9)), 1'b1);
  endtask

  task automatic test_random();
    int doc;
    doc = 0;
    while (bytes_sent < ITEMS) begin
      quiet = (doc >= 5 && doc < 9);
      send_document($urandom_range(1, 8));
      doc++;
    end
    quiet = 1'b0;
  endtask

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** text_to_bencode_converter: FAILED **");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_containers();
    test_integers();
    test_strings();
    test_errors();
    test_overflow();
    test_backpressure();
    test_random();
    s_tvalid <= 1'b0;
    while (expected_bencode.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("run: %0d input bytes (%0d parsed) in %0d documents, %0d output words checked",
             bytes_sent, live_items, documents, words_seen);
    $display("run: tokens, strings with escapes and hex, all error kinds, long receiver stall");
    if (mismatches == 0 && expected_bencode.size() == 0) begin
      $display("** text_to_bencode_converter: PASSED **");
    end else begin
      $display("mismatches: %0d, words still expected: %0d", mismatches,
               expected_bencode.size());
      $display("** text_to_bencode_converter: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
